// ===== design/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types and constants for the Manchester edge timing decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int DATA_BYTES_DEFAULT = 64;

  localparam int TICK_W  = 16;
  localparam int SHIFT_W = 16;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int FDB_W   = 7;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // event kinds
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_EDGE    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 2'd3;

  localparam logic [TICK_W-1:0]  TICK_MAX      = 16'hFFFF;
  localparam logic [SHIFT_W-1:0] SYNC_FALL_BIT = 16'h4000;
  localparam logic [SHIFT_W-1:0] SYNC_RISE_BIT = 16'h8000;
  localparam logic [FDB_W-1:0]   FDB_RESET     = 7'd1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_FALL = 2'd1,
    EDGE_RISE = 2'd2
  } edge_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       line_level;
  } evt_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last;
    logic               timed_out;
  } res_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] sync_word;
    logic [TICK_W-1:0]  bit_gap_threshold;
    logic [TICK_W-1:0]  timeout_ticks;
  } cfg_t;

endpackage

// ===== design/mtd_cfg.sv =====
// ----------------------------------------------------------------------------
// mtd_cfg
// Configuration registers and frame length clamp.
// ----------------------------------------------------------------------------
module mtd_cfg #(
  parameter int MAX_DATA_BYTES = mtd_pkg::DATA_BYTES_DEFAULT,
  parameter int LEN_W = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtd_pkg::CFG_W-1:0]     cfg_data,
  output mtd_pkg::cfg_t                 cfg,
  output logic [LEN_W-1:0]              frame_len
);

  logic [mtd_pkg::FDB_W-1:0] frame_data_bytes;
  logic [LEN_W-1:0]          fdb_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg              <= '0;
      frame_data_bytes <= mtd_pkg::FDB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtd_pkg::REG_SYNC_WORD:   cfg.sync_word         <= cfg_data;
        mtd_pkg::REG_GAP_THRESH:  cfg.bit_gap_threshold <= cfg_data;
        mtd_pkg::REG_TIMEOUT:     cfg.timeout_ticks     <= cfg_data;
        mtd_pkg::REG_FRAME_BYTES: frame_data_bytes      <= cfg_data[mtd_pkg::FDB_W-1:0];
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    fdb_ext = LEN_W'(frame_data_bytes);
    if (fdb_ext == '0) begin
      frame_len = LEN_W'(1);
    end else if (fdb_ext > LEN_W'(MAX_DATA_BYTES)) begin
      frame_len = LEN_W'(MAX_DATA_BYTES);
    end else begin
      frame_len = fdb_ext;
    end
  end

endmodule

// ===== design/mtd_core.sv =====
// ----------------------------------------------------------------------------
// mtd_core
// Event register and single-pass decode of ticks, edges and restarts.
// ----------------------------------------------------------------------------
module mtd_core #(
  parameter int LEN_W = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_ready,
  input  mtd_pkg::evt_t      evt,
  input  mtd_pkg::cfg_t      cfg,
  input  logic [LEN_W-1:0]   frame_len,
  input  logic               q_room,
  output logic               push,
  output mtd_pkg::res_t      push_res
);

  logic                          s1_valid;
  mtd_pkg::evt_t                 s1_evt;
  logic                          advance;

  mtd_pkg::phase_t               phase, phase_next;
  logic                          active, active_next;
  logic [mtd_pkg::TICK_W-1:0]    tick_count, tick_count_next;
  mtd_pkg::edge_t                prev_edge, prev_edge_next;
  logic [mtd_pkg::SHIFT_W-1:0]   sync_shift, sync_shift_next;
  logic [2:0]                    bit_pos, bit_pos_next;
  logic [LEN_W-1:0]              byte_count, byte_count_next;
  logic [mtd_pkg::BYTE_W-1:0]    cur_byte, cur_byte_next;

  assign advance   = s1_valid && q_room;
  assign evt_ready = !s1_valid || q_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt_ready) begin
      s1_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_ready && evt_valid) begin
      s1_evt <= evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= mtd_pkg::PH_IDLE;
      active     <= 1'b0;
      tick_count <= '0;
      prev_edge  <= mtd_pkg::EDGE_NONE;
      sync_shift <= '0;
      bit_pos    <= '0;
      byte_count <= '0;
      cur_byte   <= '0;
    end else begin
      phase      <= phase_next;
      active     <= active_next;
      tick_count <= tick_count_next;
      prev_edge  <= prev_edge_next;
      sync_shift <= sync_shift_next;
      bit_pos    <= bit_pos_next;
      byte_count <= byte_count_next;
      cur_byte   <= cur_byte_next;
    end
  end

  always_comb begin
    logic [mtd_pkg::TICK_W-1:0]  tick_tmp;
    logic [mtd_pkg::SHIFT_W-1:0] shift_tmp;
    logic [mtd_pkg::BYTE_W-1:0]  byte_tmp;
    logic [LEN_W-1:0]            count_inc;
    mtd_pkg::edge_t              cur;
    logic                        counted;

    phase_next      = phase;
    active_next     = active;
    tick_count_next = tick_count;
    prev_edge_next  = prev_edge;
    sync_shift_next = sync_shift;
    bit_pos_next    = bit_pos;
    byte_count_next = byte_count;
    cur_byte_next   = cur_byte;
    push            = 1'b0;
    push_res        = '0;

    tick_tmp  = tick_count;
    cur       = s1_evt.line_level ? mtd_pkg::EDGE_RISE : mtd_pkg::EDGE_FALL;
    counted   = tick_count >= cfg.bit_gap_threshold;
    shift_tmp = sync_shift | (cur == mtd_pkg::EDGE_RISE ? mtd_pkg::SYNC_RISE_BIT : '0);
    byte_tmp  = cur_byte | (cur == mtd_pkg::EDGE_RISE ?
                            (mtd_pkg::BYTE_W'(1) << bit_pos) : '0);
    count_inc = byte_count + LEN_W'(1);

    if (advance) begin
      unique case (s1_evt.mode)
        mtd_pkg::MODE_TICK: begin
          if (active) begin
            if (phase == mtd_pkg::PH_DATA && tick_count >= cfg.timeout_ticks) begin
              push               = 1'b1;
              push_res.data_byte  = cur_byte;
              push_res.byte_index = byte_count[mtd_pkg::INDEX_W-1:0];
              push_res.last       = 1'b1;
              push_res.timed_out  = 1'b1;
              tick_tmp           = '0;
              active_next        = 1'b0;
              prev_edge_next     = mtd_pkg::EDGE_NONE;
              phase_next         = mtd_pkg::PH_DONE;
            end
            if (tick_tmp != mtd_pkg::TICK_MAX) begin
              tick_tmp = tick_tmp + 1'b1;
            end
            tick_count_next = tick_tmp;
          end
        end
        mtd_pkg::MODE_EDGE: begin
          prev_edge_next = cur;
          unique case (phase)
            mtd_pkg::PH_IDLE: begin
              if (!active) begin
                active_next     = 1'b1;
                tick_count_next = '0;
              end else if (prev_edge != mtd_pkg::EDGE_NONE && prev_edge != cur) begin
                if (counted) begin
                  sync_shift_next = (cur == mtd_pkg::EDGE_FALL) ?
                                    (mtd_pkg::SYNC_FALL_BIT >> 1) :
                                    (mtd_pkg::SYNC_RISE_BIT >> 1);
                  cur_byte_next   = '0;
                  phase_next      = mtd_pkg::PH_HUNT;
                end
                tick_count_next = '0;
              end
            end
            mtd_pkg::PH_HUNT: begin
              if (counted) begin
                if (shift_tmp == cfg.sync_word) begin
                  sync_shift_next = shift_tmp;
                  phase_next      = mtd_pkg::PH_DATA;
                  bit_pos_next    = '0;
                  byte_count_next = '0;
                  cur_byte_next   = '0;
                end else begin
                  sync_shift_next = shift_tmp >> 1;
                end
                tick_count_next = '0;
              end
            end
            mtd_pkg::PH_DATA: begin
              if (counted) begin
                bit_pos_next    = bit_pos + 1'b1;
                tick_count_next = '0;
                if (bit_pos == 3'd7) begin
                  push                = 1'b1;
                  push_res.data_byte  = byte_tmp;
                  push_res.byte_index = byte_count[mtd_pkg::INDEX_W-1:0];
                  push_res.timed_out  = 1'b0;
                  byte_count_next     = count_inc;
                  cur_byte_next       = '0;
                  if (count_inc >= frame_len) begin
                    push_res.last = 1'b1;
                    active_next   = 1'b0;
                    phase_next    = mtd_pkg::PH_DONE;
                  end
                end else begin
                  cur_byte_next = byte_tmp;
                end
              end
            end
            mtd_pkg::PH_DONE: begin
            end
          endcase
        end
        mtd_pkg::MODE_RESTART: begin
          phase_next = mtd_pkg::PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/mtd_outq.sv =====
// ----------------------------------------------------------------------------
// mtd_outq
// Two-entry result queue between the decoder and the result channel.
// ----------------------------------------------------------------------------
module mtd_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mtd_pkg::res_t push_res,
  output logic          q_room,
  output logic          res_valid,
  input  logic          res_ready,
  output mtd_pkg::res_t res
);

  mtd_pkg::res_t mem [2];
  logic          head;
  logic          tail;
  logic [1:0]    count;
  logic          pop;

  assign q_room    = count != 2'd2;
  assign res_valid = count != 2'd0;
  assign pop       = res_valid && res_ready;
  assign res       = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/manchester_edge_timing_decoder.sv =====
// ----------------------------------------------------------------------------
// manchester_edge_timing_decoder
// Manchester decoder timed by line edges and ticks, with sync word hunt.
// ----------------------------------------------------------------------------
// Event channel evt (evt_valid/evt_ready) carries ticks, line edges with the
// new level, and restart requests. Result channel res (res_valid/res_ready)
// carries decoded payload bytes with their index, a last flag and a timeout
// flag. The user must write registers through cfg_we/cfg_index/cfg_data only while
// the decoder is idle; the block itself does not enforce this.
// Each event is taken into an input register and decoded from there once the
// result queue has room; a result it produces is written into the queue and
// shows on res from the queue's head.
// One event is taken every cycle while the result queue has room; the decode
// logic is a single compare and shift pass on the event register.
// A two-entry result queue sits in front of res; while the receiver stalls,
// events keep flowing until the queue is full, then evt_ready drops.
// Reset clears all decode state to not synchronized and inactive, empties
// the queue and restores register defaults.
// ----------------------------------------------------------------------------
module manchester_edge_timing_decoder #(
  parameter int MAX_DATA_BYTES = mtd_pkg::DATA_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          evt_valid,
  output logic                          evt_ready,
  input  mtd_pkg::evt_t                 evt,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mtd_pkg::res_t                 res,
  input  logic                          cfg_we,
  input  logic [mtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_DATA_BYTES + 1);
  localparam int LEN_W = (CNT_W > mtd_pkg::FDB_W) ? CNT_W : mtd_pkg::FDB_W;

  mtd_pkg::cfg_t    cfg;
  logic [LEN_W-1:0] frame_len;
  logic             q_room;
  logic             push;
  mtd_pkg::res_t    push_res;

  mtd_cfg #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .LEN_W          (LEN_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .frame_len (frame_len)
  );

  mtd_core #(
    .LEN_W (LEN_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .cfg       (cfg),
    .frame_len (frame_len),
    .q_room    (q_room),
    .push      (push),
    .push_res  (push_res)
  );

  mtd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .q_room    (q_room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== design/mtd_checker.sv =====
// ----------------------------------------------------------------------------
// mtd_checker
// Port-level checks for the Manchester edge timing decoder.
// ----------------------------------------------------------------------------
module mtd_checker (
  input logic          clk,
  input logic          rst,
  input logic          evt_valid,
  input logic          evt_ready,
  input mtd_pkg::evt_t evt,
  input logic          res_valid,
  input logic          res_ready,
  input mtd_pkg::res_t res
);

  // waiting event holds
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt))
    else $error("event changed while waiting");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // a timeout always ends the frame
  a_timeout_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.timed_out |-> res.last)
    else $error("timeout without last");

  // queue empty and input open right after reset
  a_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid && evt_ready)
    else $error("not empty after reset");

  // a result never shows up the cycle after a reset release with no event
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result right after reset");

endmodule

bind manchester_edge_timing_decoder mtd_checker u_mtd_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt_valid),
  .evt_ready (evt_ready),
  .evt       (evt),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// ===== test/tb_manchester_edge_timing_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_manchester_edge_timing_decoder
// Self-checking bench for the Manchester edge timing decoder. A short directed
// sequence comes first. Random frames follow, each with a preamble, a sync
// word and a payload, mixed with noise, broken sync and timeouts, over
// several register settings. An event-level model of the decoder predicts
// every byte, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_manchester_edge_timing_decoder;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_BYTES      = mtd_pkg::DATA_BYTES_DEFAULT;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_ITEMS     = 1450;
  localparam int PHASE_ITEMS    = 160;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [7:0] DIR_BYTE    = 8'hB5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_ready;
  mtd_pkg::evt_t evt = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  mtd_pkg::res_t res;
  logic cfg_we = 1'b0;
  logic [mtd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mtd_pkg::CFG_W-1:0] cfg_data = '0;

  manchester_edge_timing_decoder #(
    .MAX_DATA_BYTES(MAX_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt      (evt),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder model state and register copies
  logic [mtd_pkg::SHIFT_W-1:0] c_sync = '0;
  logic [mtd_pkg::TICK_W-1:0]  c_gap  = '0;
  logic [mtd_pkg::TICK_W-1:0]  c_tmo  = '0;
  logic [mtd_pkg::FDB_W-1:0]   c_fdb  = mtd_pkg::FDB_RESET;

  mtd_pkg::phase_t             m_phase  = mtd_pkg::PH_IDLE;
  logic                        m_active = 1'b0;
  logic [mtd_pkg::TICK_W-1:0]  m_ticks  = '0;
  mtd_pkg::edge_t              m_prev   = mtd_pkg::EDGE_NONE;
  logic [mtd_pkg::SHIFT_W-1:0] m_shift  = '0;
  int                          m_bitpos = 0;
  int                          m_bytes  = 0;
  logic [mtd_pkg::BYTE_W-1:0]  m_byte   = '0;

  mtd_pkg::evt_t pending[$];
  mtd_pkg::res_t expected_bytes[$];
  mtd_pkg::res_t want_r;

  int evts_queued = 0;
  int evts_taken = 0;
  int bytes_seen = 0;
  int frames_ended = 0;
  int frames_timed_out = 0;
  int settings_run = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit progress;

  int burst_left = 0;
  int gap_left = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int ready_style = 0;
  int style_cnt = 0;
  logic line = 1'b0;

  function automatic int frame_len();
    if (c_fdb == 0) return 1;
    if (c_fdb > MAX_BYTES) return MAX_BYTES;
    return int'(c_fdb);
  endfunction

  function automatic void decode_event(mtd_pkg::evt_t e);
    mtd_pkg::edge_t cur;
    logic counted;
    mtd_pkg::res_t r;
    cur = e.line_level ? mtd_pkg::EDGE_RISE : mtd_pkg::EDGE_FALL;
    counted = (m_ticks >= c_gap);
    r = '0;
    case (e.mode)
      mtd_pkg::MODE_TICK: begin
        if (m_active) begin
          if (m_phase == mtd_pkg::PH_DATA && m_ticks >= c_tmo) begin
            r.data_byte = m_byte;
            r.byte_index = m_bytes[mtd_pkg::INDEX_W-1:0];
            r.last = 1'b1;
            r.timed_out = 1'b1;
            expected_bytes.push_back(r);
            m_ticks = '0;
            m_active = 1'b0;
            m_prev = mtd_pkg::EDGE_NONE;
            m_phase = mtd_pkg::PH_DONE;
          end
          if (m_ticks != mtd_pkg::TICK_MAX) m_ticks++;
        end
      end
      mtd_pkg::MODE_EDGE: begin
        case (m_phase)
          mtd_pkg::PH_IDLE: begin
            if (!m_active) begin
              m_active = 1'b1;
              m_ticks = '0;
            end else if (m_prev != mtd_pkg::EDGE_NONE && m_prev != cur) begin
              if (counted) begin
                m_shift = (cur == mtd_pkg::EDGE_FALL) ? (mtd_pkg::SYNC_FALL_BIT >> 1) :
                                                        (mtd_pkg::SYNC_RISE_BIT >> 1);
                m_byte = '0;
                m_phase = mtd_pkg::PH_HUNT;
              end
              m_ticks = '0;
            end
          end
          mtd_pkg::PH_HUNT: begin
            if (counted) begin
              if (cur == mtd_pkg::EDGE_RISE) m_shift = m_shift | mtd_pkg::SYNC_RISE_BIT;
              if (m_shift == c_sync) begin
                m_phase = mtd_pkg::PH_DATA;
                m_bitpos = 0;
                m_bytes = 0;
                m_byte = '0;
              end else begin
                m_shift = m_shift >> 1;
              end
              m_ticks = '0;
            end
          end
          mtd_pkg::PH_DATA: begin
            if (counted) begin
              if (cur == mtd_pkg::EDGE_RISE) m_byte[m_bitpos] = 1'b1;
              m_bitpos++;
              if (m_bitpos >= mtd_pkg::BYTE_W) begin
                r.data_byte = m_byte;
                r.byte_index = m_bytes[mtd_pkg::INDEX_W-1:0];
                r.timed_out = 1'b0;
                m_bitpos = 0;
                m_bytes++;
                r.last = (m_bytes >= frame_len());
                if (r.last) begin
                  m_active = 1'b0;
                  m_phase = mtd_pkg::PH_DONE;
                end
                expected_bytes.push_back(r);
                m_byte = '0;
              end
              m_ticks = '0;
            end
          end
          default: ;
        endcase
        m_prev = cur;
      end
      mtd_pkg::MODE_RESTART: m_phase = mtd_pkg::PH_IDLE;
      default: ;
    endcase
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || evt_ready) begin
      if (gap_left != 0 || pending.size() == 0) begin
        if (gap_left != 0) gap_left--;
        evt_valid <= 1'b0;
      end else begin
        evt <= pending.pop_front();
        evt_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: changing stall styles, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      res_ready <= 1'b0;
    end else begin
      if (style_cnt == 0) begin
        ready_style = $urandom_range(0, 3);
        style_cnt = $urandom_range(20, 80);
      end else begin
        style_cnt--;
      end
      case (ready_style)
        0: res_ready <= 1'b1;
        1: res_ready <= 1'($urandom_range(0, 1));
        2: res_ready <= ($urandom_range(0, 7) != 0);
        default: res_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (evt_valid && evt_ready) begin
        progress = 1'b1;
        evts_taken++;
        decode_event(evt);
      end
      if (res_valid && res_ready) begin
        progress = 1'b1;
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected nothing actual %h", $time, res);
        end else begin
          want_r = expected_bytes.pop_front();
          check_field("data_byte", int'(want_r.data_byte), int'(res.data_byte));
          check_field("byte_index", int'(want_r.byte_index), int'(res.byte_index));
          check_field("last", int'(want_r.last), int'(res.last));
          check_field("timed_out", int'(want_r.timed_out), int'(res.timed_out));
          bytes_seen++;
          if (res.last) frames_ended++;
          if (res.timed_out) frames_timed_out++;
        end
      end
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, expected_bytes.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [mtd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mtd_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mtd_pkg::REG_SYNC_WORD:   c_sync = val;
      mtd_pkg::REG_GAP_THRESH:  c_gap = val;
      mtd_pkg::REG_TIMEOUT:     c_tmo = val;
      mtd_pkg::REG_FRAME_BYTES: c_fdb = val[mtd_pkg::FDB_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [mtd_pkg::CFG_W-1:0] sync,
                            input logic [mtd_pkg::CFG_W-1:0] gap,
                            input logic [mtd_pkg::CFG_W-1:0] tmo,
                            input logic [mtd_pkg::CFG_W-1:0] fdb);
    cfg_write(mtd_pkg::REG_SYNC_WORD, sync);
    cfg_write(mtd_pkg::REG_GAP_THRESH, gap);
    cfg_write(mtd_pkg::REG_TIMEOUT, tmo);
    cfg_write(mtd_pkg::REG_FRAME_BYTES, fdb);
    @(negedge clk);
    settings_run++;
  endtask

  task automatic settle();
    @(negedge clk);
    while (evts_taken != evts_queued || expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_evt(input logic [1:0] mode, input logic level);
    mtd_pkg::evt_t e;
    e.mode = mode;
    e.line_level = level;
    pending.push_back(e);
    evts_queued++;
  endtask

  // one bit cell: mid-cell transition if needed, then the counted edge
  task automatic send_bit(input logic v);
    int j;
    j = (c_tmo > c_gap) ? $urandom_range(0, 1) : 0;
    if (c_gap != 0 && line == v) push_evt(mtd_pkg::MODE_EDGE, ~v);
    repeat (int'(c_gap) + j) push_evt(mtd_pkg::MODE_TICK, 1'($urandom_range(0, 1)));
    push_evt(mtd_pkg::MODE_EDGE, v);
    line = v;
  endtask

  task automatic send_frame();
    int flen, nbits, hi, bad;
    logic tmo_end;
    flen = frame_len();
    tmo_end = (c_tmo != mtd_pkg::TICK_MAX) && (flen > 4 || $urandom_range(0, 2) == 0);
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(3, 12))
        push_evt(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    push_evt(mtd_pkg::MODE_RESTART, 1'($urandom_range(0, 1)));
    line = ~line;
    push_evt(mtd_pkg::MODE_EDGE, line);
    repeat ($urandom_range(0, 4)) send_bit(1'($urandom_range(0, 1)));
    bad = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 15)) : -1;
    for (int i = 0; i < mtd_pkg::SHIFT_W; i++) send_bit(c_sync[i] ^ (i == bad));
    hi = (flen - 1 < 3) ? flen - 1 : 3;
    nbits = tmo_end ? int'($urandom_range(0, hi)) * mtd_pkg::BYTE_W +
                      int'($urandom_range(0, 7)) : flen * mtd_pkg::BYTE_W;
    repeat (nbits) send_bit(1'($urandom_range(0, 1)));
    if (tmo_end)
      repeat (int'(c_tmo) + 1 + int'($urandom_range(0, 1)))
        push_evt(mtd_pkg::MODE_TICK, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int p, rand_start, phase_start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored events, activation, seed, quick sync, full byte, timeout
    set_config(16'hA000, 16'd0, 16'd2, 16'd1);
    push_evt(MODE_UNUSED, 1'b1);
    push_evt(mtd_pkg::MODE_TICK, 1'b1);
    push_evt(mtd_pkg::MODE_RESTART, 1'b0);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b0);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    for (int i = 0; i < mtd_pkg::BYTE_W; i++) push_evt(mtd_pkg::MODE_EDGE, DIR_BYTE[i]);
    push_evt(mtd_pkg::MODE_EDGE, 1'b0);
    push_evt(mtd_pkg::MODE_RESTART, 1'b1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b0);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b0);
    repeat (3) push_evt(mtd_pkg::MODE_TICK, 1'b0);
    settle();

    set_config(c_sync, 16'd0, mtd_pkg::TICK_MAX, 16'd1);
    push_evt(mtd_pkg::MODE_EDGE, 1'b1);
    repeat (mtd_pkg::BYTE_W) push_evt(mtd_pkg::MODE_EDGE, 1'($urandom_range(0, 1)));
    line = 1'b0;
    push_evt(mtd_pkg::MODE_EDGE, line);
    settle();

    rand_start = evts_queued;
    for (p = 0; evts_queued - rand_start < RAND_ITEMS; p++) begin
      case (p)
        0: set_config(16'($urandom), 16'd0, 16'd0, 16'd2);
        1: set_config(16'hFFFF, 16'd1, 16'd3, 16'd3);
        2: set_config(16'h0000, 16'd2, mtd_pkg::TICK_MAX, 16'd0);
        3: set_config(16'($urandom), 16'd3, 16'd5, 16'd64);
        4: set_config(16'($urandom), 16'd0, mtd_pkg::TICK_MAX, 16'd100);
        5: set_config(16'($urandom), 16'd1, 16'd2, 16'hFF82);
        default: begin
          c_gap = 16'($urandom_range(0, 3));
          set_config(16'($urandom), c_gap, 16'(int'(c_gap) + int'($urandom_range(0, 4))),
                     16'($urandom_range(1, 4)));
        end
      endcase
      if (p == 4) hold_req = 1'b1;
      phase_start = evts_queued;
      while (evts_queued - phase_start < PHASE_ITEMS) send_frame();
      settle();
    end

    $display("covered %0d events over %0d register settings",
             evts_taken, settings_run);
    $display("checked %0d bytes, %0d frame ends, %0d of them by timeout, %0d mismatches",
             bytes_seen, frames_ended, frames_timed_out, errors);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== manchester_edge_timing_decoder.f =====
design/mtd_pkg.sv
design/mtd_cfg.sv
design/mtd_core.sv
design/mtd_outq.sv
design/manchester_edge_timing_decoder.sv
design/mtd_checker.sv
test/tb_manchester_edge_timing_decoder.sv
